>>> sv/bcp_pkg.sv
package bcp_pkg;

  // Default largest row the pipeline can build
  localparam int MAX_N_DEF = 32;

  // Field widths
  localparam int CNT_W  = 6;
  localparam int IDX_W  = CNT_W + 1;
  localparam int COEF_W = 32;

  // Input item packing in tdata
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // Control that travels with each row down the pipeline
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] k;
    logic             skip;  // answer is forced to zero, no row work
    logic             ovf;   // some sum saturated so far
  } bcp_ctl_t;

endpackage

>>> sv/binomial_coefficient_pascal_unit.sv
// Binomial coefficient unit: each input item carries n and k and yields one
// result item with C(n,k), saturated at 2^32-1, and an overflow flag. The
// block is a pipeline of MAX_N row stages, each adding neighboring entries
// of one row of Pascal's triangle (columns 0..k only), then an output
// register that selects column k. A new item can be accepted in every cycle;
// stages fill bubbles independently, so a stalled output only blocks once
// the pipeline is full. k greater than n answers 0 with no overflow; n
// greater than MAX_N answers 0 with overflow set. Saturation needs MAX_N of
// 35 or more.
module binomial_coefficient_pascal_unit #(
  parameter int MAX_N = bcp_pkg::MAX_N_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [bcp_pkg::IN_TDATA_W-1:0]     s_tdata,   // [5:0] row_count, [11:6] choose_count
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bcp_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [31:0] coefficient
  output logic                               m_tuser    // [0] overflow
);
  import bcp_pkg::*;

  logic [MAX_N:0]                       v;
  logic [MAX_N:0]                       rdy;
  bcp_ctl_t                             ctl [MAX_N+1];
  logic [MAX_N:0][MAX_N:0][COEF_W-1:0]  row;
  logic                                 refuse;

  // Entry: decode the item and seed row 0
  assign refuse = {1'b0, s_tdata[CNT_W-1:0]} > IDX_W'(MAX_N);

  // Fields n, k, skip, ovf from the top bit down
  assign ctl[0] = {s_tdata[CNT_W-1:0], s_tdata[2*CNT_W-1:CNT_W],
                   refuse || (s_tdata[2*CNT_W-1:CNT_W] > s_tdata[CNT_W-1:0]),
                   refuse};
  assign row[0] = ((MAX_N+1)*COEF_W)'(1);

  assign v[0]     = s_tvalid;
  assign s_tready = rdy[0];

  // One stage per row of the triangle
  for (genvar s = 1; s <= MAX_N; s++) begin : g_row
    bcp_row_stage #(
      .MAX_N (MAX_N),
      .ROW   (s)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[s-1]),
      .in_ready  (rdy[s-1]),
      .in_ctl    (ctl[s-1]),
      .in_row    (row[s-1]),
      .out_valid (v[s]),
      .out_ready (rdy[s]),
      .out_ctl   (ctl[s]),
      .out_row   (row[s])
    );
  end

  // Column select and result register
  bcp_out_reg #(
    .MAX_N (MAX_N)
  ) u_out (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v[MAX_N]),
    .in_ready    (rdy[MAX_N]),
    .in_ctl      (ctl[MAX_N]),
    .in_row      (row[MAX_N]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .coefficient (m_tdata),
    .overflow    (m_tuser)
  );

`ifndef SYNTHESIS
  // An accepted item lands in the first row stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v[0+1])
    else $error("accepted item missing from first stage");

  // Last row stage keeps its item while the result register is blocked
  a_hold: assert property (@(posedge clk) disable iff (rst)
    v[MAX_N] && !rdy[MAX_N] |=> v[MAX_N])
    else $error("item lost at result register");

  // Without saturation, overflow only marks a refused item
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && (MAX_N <= 34) |-> m_tdata == '0)
    else $error("overflow with nonzero coefficient");
`endif

endmodule

>>> sv/bcp_row_stage.sv
module bcp_row_stage #(
  parameter int MAX_N = bcp_pkg::MAX_N_DEF,
  parameter int ROW   = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  bcp_pkg::bcp_ctl_t                     in_ctl,
  input  logic [MAX_N:0][bcp_pkg::COEF_W-1:0]   in_row,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output bcp_pkg::bcp_ctl_t                     out_ctl,
  output logic [MAX_N:0][bcp_pkg::COEF_W-1:0]   out_row
);
  import bcp_pkg::*;

  localparam logic [IDX_W-1:0] ROW_I = IDX_W'(ROW);

  logic                          active;
  logic [MAX_N:1][COEF_W:0]      sum;
  logic [MAX_N:0][COEF_W-1:0]    row_next;
  bcp_ctl_t                      ctl_next;

  // This row is built only if the item needs it
  assign active = !in_ctl.skip && ({1'b0, in_ctl.n} >= ROW_I);

  // Neighbor sums with a carry bit for saturation
  always_comb begin
    for (int j = 1; j <= MAX_N; j++) begin
      sum[j] = {1'b0, in_row[j]} + {1'b0, in_row[j-1]};
    end
  end

  // Row update: columns 1..min(ROW-1,k) add, column ROW starts at one if ROW <= k
  always_comb begin
    row_next = in_row;
    ctl_next = in_ctl;
    for (int j = 1; j <= MAX_N; j++) begin
      if (active && (j < ROW) && (IDX_W'(j) <= {1'b0, in_ctl.k})) begin
        row_next[j]  = sum[j][COEF_W] ? '1 : sum[j][COEF_W-1:0];
        ctl_next.ovf = ctl_next.ovf | sum[j][COEF_W];
      end
    end
    if (active && (ROW_I <= {1'b0, in_ctl.k})) begin
      row_next[ROW] = COEF_W'(1);
    end
  end

  // Stage register, fills whenever empty or draining
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_ctl <= ctl_next;
      out_row <= row_next;
    end
  end

endmodule

>>> sv/bcp_out_reg.sv
module bcp_out_reg #(
  parameter int MAX_N = bcp_pkg::MAX_N_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  bcp_pkg::bcp_ctl_t                     in_ctl,
  input  logic [MAX_N:0][bcp_pkg::COEF_W-1:0]   in_row,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bcp_pkg::COEF_W-1:0]            coefficient,
  output logic                                  overflow
);
  import bcp_pkg::*;

  localparam int SEL_W = $clog2(MAX_N + 1);

  logic [SEL_W-1:0]  sel;
  logic [COEF_W-1:0] coef_next;

  // Pick column k; skipped items answer zero
  assign sel = SEL_W'(in_ctl.k);

  always_comb begin
    coef_next = '0;
    if (!in_ctl.skip && ({1'b0, in_ctl.k} <= IDX_W'(MAX_N))) begin
      coef_next = in_row[sel];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      coefficient <= coef_next;
      overflow    <= in_ctl.ovf;
    end
  end

endmodule

>>> tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcp_pkg::*;

  localparam int ROW_LIMIT = MAX_N_DEF;
  localparam int FIELD_MAX = (1 << CNT_W) - 1;
  localparam int RAND_PER_PHASE = 300;

  // Expected answer for one accepted query
  typedef struct {
    bit [CNT_W-1:0]  n;
    bit [CNT_W-1:0]  k;
    bit [COEF_W-1:0] coefficient;
    bit              overflow;
  } binom_answer_t;

  // Keeps its own Pascal row and the queue of answers still owed by the block
  class binom_checker;
    bit [COEF_W-1:0] pascal_row [0:ROW_LIMIT];
    binom_answer_t   owed_answers[$];
    int              errors;

    function new();
      foreach (pascal_row[i]) pascal_row[i] = '0;
      errors = 0;
    endfunction

    // Builds rows 1..n in place, columns 0..k only, saturating each sum
    function void pascal_predict(input bit [CNT_W-1:0] n, input bit [CNT_W-1:0] k,
                                 output bit [COEF_W-1:0] coef, output bit ovf);
      int top;
      bit [COEF_W:0] sum;
      ovf  = 1'b0;
      coef = '0;
      if (n > ROW_LIMIT) begin
        ovf = 1'b1;
        return;
      end
      if (k > n) return;
      pascal_row[0] = 1;
      for (int i = 1; i <= n; i++) begin
        top = (i - 1 < k) ? i - 1 : k;
        for (int j = top; j >= 1; j--) begin
          sum = {1'b0, pascal_row[j]} + {1'b0, pascal_row[j-1]};
          if (sum[COEF_W]) begin
            ovf = 1'b1;
            pascal_row[j] = '1;
          end else begin
            pascal_row[j] = sum[COEF_W-1:0];
          end
        end
        if (i <= k) pascal_row[i] = 1;
      end
      coef = pascal_row[k];
    endfunction

    function void note_query(bit [CNT_W-1:0] n, bit [CNT_W-1:0] k);
      binom_answer_t a;
      a.n = n;
      a.k = k;
      pascal_predict(n, k, a.coefficient, a.overflow);
      owed_answers.push_back(a);
    endfunction

    function void check_answer(bit [COEF_W-1:0] coef, bit ovf);
      binom_answer_t a;
      if (owed_answers.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result coefficient=%0d overflow=%0b", coef, ovf);
        return;
      end
      a = owed_answers.pop_front();
      if (coef !== a.coefficient || ovf !== a.overflow) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: n=%0d k=%0d expected coefficient=%0d overflow=%0b, got %0d %0b",
                   a.n, a.k, a.coefficient, a.overflow, coef, ovf);
      end
    endfunction

    function int pending();
      return owed_answers.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [5:0] row_count, [11:6] choose_count
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [31:0] coefficient
  logic                   m_tuser;        // [0] overflow

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  binom_checker chk;

  binomial_coefficient_pascal_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Receiver backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Note accepted queries, then check accepted results
  always @(posedge clk) begin
    if (!rst && chk != null) begin
      if (s_tvalid && s_tready)
        chk.note_query(s_tdata[CNT_W-1:0], s_tdata[2*CNT_W-1:CNT_W]);
      if (m_tvalid && m_tready)
        chk.check_answer(m_tdata[COEF_W-1:0], m_tuser);
    end
  end

  // Offer one query, with random idle cycles ahead of it, and hold until taken
  task automatic send_query(int n, int k);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({k[CNT_W-1:0], n[CNT_W-1:0]});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Mostly valid k <= n <= MAX_N, some k > n, some n beyond the row store
  task automatic send_random_query();
    int r, n, k;
    r = $urandom_range(99);
    if (r < 70) begin
      n = $urandom_range(ROW_LIMIT);
      k = $urandom_range(n);
    end else if (r < 85) begin
      n = $urandom_range(ROW_LIMIT);
      k = $urandom_range(FIELD_MAX);
    end else begin
      n = $urandom_range(FIELD_MAX);
      k = $urandom_range(FIELD_MAX);
    end
    send_query(n, k);
  endtask

  initial begin
    int dir_n [] = '{0, 1, 1, 0, 32, 32, 32, 32, 33, 63, 63, 0, 31, 5, 10, 20, 32, 40,
                     35, 16, 62, 21, 42};
    int dir_k [] = '{0, 0, 1, 1, 16, 32, 0, 31, 0, 63, 0, 63, 32, 2, 3, 10, 33, 20,
                     35, 63, 1, 42, 21};
    int idle_pct  [4] = '{0, 72, 0, 34};
    int stall_pct [4] = '{0, 0, 72, 34};

    chk = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, k beyond n, n beyond the row store
    foreach (dir_n[i]) send_query(dir_n[i], dir_k[i]);

    // Random traffic under each idling pattern
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      repeat (RAND_PER_PHASE) send_random_query();
    end
    s_tvalid <= 1'b0;

    // Drain, then give stray results time to show up
    while (chk.pending() != 0) @(posedge clk);
    repeat (2 * ROW_LIMIT + 8) @(posedge clk);

    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
sv/bcp_pkg.sv
sv/bcp_row_stage.sv
sv/bcp_out_reg.sv
sv/binomial_coefficient_pascal_unit.sv
tb/sv/tb.sv
